@@ hw/rtl/crt_pkg.sv @@
`default_nettype none
package crt_pkg;
    localparam int MAX_EQUATIONS = 4;
    localparam int MODULUS_BITS = 16;
    localparam int WIDE = 64;
    localparam int CNT_W = 3;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_COPRIME = 2'd1,
        ST_TOO_MANY    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RED_M,
        S_EUCLID,
        S_RED_R,
        S_RED_A,
        S_KLOAD,
        S_RED_K,
        S_MULK,
        S_MULM,
        S_OUT
    } state_t;

    // Operand that the remainder unit is loaded with.
    typedef enum logic [1:0] {
        RED_RMOD,
        RED_RRES,
        RED_A,
        RED_K
    } red_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     set_nc;
        logic     red_start;
        red_src_t red_src;
        logic     red_step;
        logic     eu_start;
        logic     eu_step;
        logic     inv_calc;
        logic     rres_save;
        logic     diff_calc;
        logic     mul_start;
        logic     mul_k;
        logic     mul_step;
        logic     acc;
        logic     mod_update;
        logic     clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic red_done;
        logic eu_done;
        logic mul_done;
        logic gcd_one;
        logic m_zero;
        logic err_set;
        logic last;
    } stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/crt_ctrl.sv @@
`default_nettype none
module crt_ctrl
    import crt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // Count and error are settled after the load cycle.
                if (st.err_set)
                begin
                    cmd.mul_start = 1'b1;
                    state_next = S_MULM;
                end
                else if (st.m_zero)
                begin
                    cmd.set_nc = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next = S_MULM;
                end
                else
                begin
                    cmd.red_start = 1'b1;
                    cmd.red_src = RED_RMOD;
                    state_next = S_RED_M;
                end
            end
            S_RED_M:
            begin
                if (st.red_done)
                begin
                    cmd.eu_start = 1'b1;
                    state_next = S_EUCLID;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_EUCLID:
            begin
                if (st.eu_done)
                begin
                    if (st.gcd_one)
                    begin
                        cmd.inv_calc = 1'b1;
                        cmd.red_start = 1'b1;
                        cmd.red_src = RED_RRES;
                        state_next = S_RED_R;
                    end
                    else
                    begin
                        cmd.set_nc = 1'b1;
                        cmd.mul_start = 1'b1;
                        state_next = S_MULM;
                    end
                end
                else
                begin
                    cmd.eu_step = 1'b1;
                end
            end
            S_RED_R:
            begin
                if (st.red_done)
                begin
                    cmd.rres_save = 1'b1;
                    cmd.red_start = 1'b1;
                    cmd.red_src = RED_A;
                    state_next = S_RED_A;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_RED_A:
            begin
                if (st.red_done)
                begin
                    cmd.diff_calc = 1'b1;
                    state_next = S_KLOAD;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_KLOAD:
            begin
                cmd.red_start = 1'b1;
                cmd.red_src = RED_K;
                state_next = S_RED_K;
            end
            S_RED_K:
            begin
                if (st.red_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_k = 1'b1;
                    state_next = S_MULK;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_MULK:
            begin
                if (st.mul_done)
                begin
                    cmd.acc = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next = S_MULM;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_MULM:
            begin
                if (st.mul_done)
                begin
                    cmd.mod_update = 1'b1;
                    state_next = st.last ? S_OUT : S_IDLE;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/crt_datapath.sv @@
`default_nettype none
module crt_datapath
    import crt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [15:0]               residue,
    input  wire logic [15:0]               modulus,
    input  wire logic                      last,
    input  wire cmd_t                      cmd,
    output stat_t                          st,
    output logic [WIDE-1:0]                solution,
    output logic [WIDE-1:0]                combined_modulus,
    output logic [1:0]                     status
);
    localparam logic [15:0] MMASK = 16'((32'd1 << MODULUS_BITS) - 1);
    localparam int RED_BITS = 7;

    logic [WIDE-1:0]     rmod_reg, rres_reg;
    status_t             err_reg, err_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [15:0]         m_reg, a_reg;
    logic                last_reg;
    // Restoring reducer: remainder of a 64-bit value by m, one bit a cycle.
    logic [WIDE-1:0]     rq_reg;
    logic [15:0]         rr_reg;
    logic [RED_BITS-1:0] rcnt_reg;
    logic [16:0]         rr_sh;
    // Operands of k = ((a - r) * inverse) mod m.
    logic [15:0]         rres_red_reg, diff_reg, inv_reg;
    logic [16:0]         diff_sum;
    logic [31:0]         kprod;
    // Euclid registers: one quotient bit a cycle, then one update.
    logic [15:0]         r0_reg, r1_reg;
    logic signed [17:0]  s0_reg, s1_reg;
    logic [15:0]         q_reg, qr_reg;
    logic [4:0]          qcnt_reg;
    logic [16:0]         qr_sh;
    logic signed [16:0]  q_s;
    logic signed [34:0]  s_prod, s_diff;
    logic signed [17:0]  inv_tmp;
    // Shift-add multiplier of the running modulus by a 16-bit factor.
    logic [WIDE-1:0]     macc_reg, mmul_reg;
    logic [15:0]         mfac_reg;
    logic [4:0]          mcnt_reg;

    assign rr_sh    = {rr_reg, rq_reg[WIDE-1]};
    assign qr_sh    = {qr_reg, r0_reg[4'd15 - qcnt_reg[3:0]]};
    assign q_s      = {1'b0, q_reg};
    assign s_prod   = 35'(q_s) * 35'(s1_reg);
    assign s_diff   = 35'(s0_reg) - s_prod;
    assign inv_tmp  = s0_reg[17] ? s0_reg + $signed({2'b00, m_reg}) : s0_reg;
    assign diff_sum = {1'b0, rr_reg} + {1'b0, m_reg} - {1'b0, rres_red_reg};
    assign kprod    = 32'(diff_reg) * 32'(inv_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (cmd.clear)
        begin
            cnt_next = '0;
            err_next = ST_OK;
        end
        else if (cmd.load)
        begin
            if (cnt_reg >= CNT_W'(MAX_EQUATIONS))
            begin
                if (err_reg == ST_OK)
                begin
                    err_next = ST_TOO_MANY;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cmd.set_nc && err_reg == ST_OK)
        begin
            err_next = ST_NOT_COPRIME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmod_reg     <= WIDE'(1);
            rres_reg     <= '0;
            err_reg      <= ST_OK;
            cnt_reg      <= '0;
            m_reg        <= '0;
            a_reg        <= '0;
            last_reg     <= 1'b0;
            rq_reg       <= '0;
            rr_reg       <= '0;
            rcnt_reg     <= '0;
            rres_red_reg <= '0;
            diff_reg     <= '0;
            inv_reg      <= '0;
            r0_reg       <= '0;
            r1_reg       <= '0;
            s0_reg       <= '0;
            s1_reg       <= '0;
            q_reg        <= '0;
            qr_reg       <= '0;
            qcnt_reg     <= '0;
            macc_reg     <= '0;
            mmul_reg     <= '0;
            mfac_reg     <= '0;
            mcnt_reg     <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            if (cmd.load)
            begin
                m_reg <= modulus & MMASK;
                a_reg <= residue;
                last_reg <= last;
            end
            // Reducer; a narrow operand starts part-way so only its bits are walked.
            if (cmd.red_start)
            begin
                rr_reg <= '0;
                unique case (cmd.red_src)
                    RED_RMOD:
                    begin
                        rq_reg <= rmod_reg;
                        rcnt_reg <= '0;
                    end
                    RED_RRES:
                    begin
                        rq_reg <= rres_reg;
                        rcnt_reg <= '0;
                    end
                    RED_A:
                    begin
                        rq_reg <= {a_reg, 48'd0};
                        rcnt_reg <= RED_BITS'(48);
                    end
                    RED_K:
                    begin
                        rq_reg <= {kprod, 32'd0};
                        rcnt_reg <= RED_BITS'(32);
                    end
                endcase
            end
            else if (cmd.red_step)
            begin
                rq_reg <= rq_reg << 1;
                rr_reg <= (rr_sh >= {1'b0, m_reg}) ? 16'(rr_sh - {1'b0, m_reg}) : rr_sh[15:0];
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            if (cmd.rres_save)
            begin
                rres_red_reg <= rr_reg;
            end
            if (cmd.diff_calc)
            begin
                diff_reg <= (diff_sum >= {1'b0, m_reg}) ? 16'(diff_sum - {1'b0, m_reg})
                                                        : diff_sum[15:0];
            end
            if (cmd.inv_calc)
            begin
                inv_reg <= inv_tmp[15:0];
            end
            // Euclid on (M mod m, m).
            if (cmd.eu_start)
            begin
                r0_reg <= rr_reg;
                r1_reg <= m_reg;
                s0_reg <= 18'sd1;
                s1_reg <= 18'sd0;
                qcnt_reg <= '0;
                qr_reg <= '0;
                q_reg <= '0;
            end
            else if (cmd.eu_step)
            begin
                if (qcnt_reg != 5'd16)
                begin
                    qcnt_reg <= qcnt_reg + 1'b1;
                    if (qr_sh >= {1'b0, r1_reg})
                    begin
                        qr_reg <= 16'(qr_sh - {1'b0, r1_reg});
                        q_reg <= {q_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        qr_reg <= qr_sh[15:0];
                        q_reg <= {q_reg[14:0], 1'b0};
                    end
                end
                else
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= qr_reg;
                    s0_reg <= s1_reg;
                    s1_reg <= s_diff[17:0];
                    qcnt_reg <= '0;
                    qr_reg <= '0;
                    q_reg <= '0;
                end
            end
            // Multiplier.
            if (cmd.mul_start)
            begin
                macc_reg <= '0;
                mmul_reg <= rmod_reg;
                mfac_reg <= cmd.mul_k ? rr_reg : m_reg;
                mcnt_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                if (mfac_reg[0])
                begin
                    macc_reg <= macc_reg + mmul_reg;
                end
                mmul_reg <= mmul_reg << 1;
                mfac_reg <= mfac_reg >> 1;
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                rmod_reg <= WIDE'(1);
                rres_reg <= '0;
            end
            else
            begin
                if (cmd.acc)
                begin
                    rres_reg <= rres_reg + macc_reg;
                end
                if (cmd.mod_update)
                begin
                    rmod_reg <= macc_reg;
                end
            end
        end
    end

    assign st.red_done = rcnt_reg == RED_BITS'(WIDE);
    assign st.eu_done  = r1_reg == 16'd0;
    assign st.mul_done = mcnt_reg == 5'd16;
    assign st.gcd_one  = r0_reg == 16'd1;
    assign st.m_zero   = m_reg == 16'd0;
    assign st.err_set  = err_reg != ST_OK;
    assign st.last     = last_reg;

    assign solution         = (err_reg == ST_OK) ? rres_reg : '0;
    assign combined_modulus = rmod_reg;
    assign status           = err_reg;
endmodule
`default_nettype wire

@@ hw/rtl/crt_solver_incremental_core.sv @@
`default_nettype none
// Incremental CRT solver: each input transaction carries one congruence,
// folded into a running system by a controller and a bit-serial datapath
// (one-bit-a-cycle remainder unit, Euclid unit with a bit-serial quotient and
// one update per step, shift-add multiplier). The block takes one item at a
// time and raises in_ready only when idle. For a good item the Euclid run
// takes 1 up to about 24 steps for 16-bit moduli; it and the two 64-bit
// reductions dominate the time. An item arriving with an error already set
// or a zero modulus goes straight to the modulus multiply. The block
// returns to idle before it accepts the next item. A result transaction
// appears only for the item marked last, and the block waits for it to be
// taken.
module crt_solver_incremental_core
    import crt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] residue,
    input  wire logic [15:0] modulus,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      solution,
    output logic [63:0]      combined_modulus,
    output logic [1:0]       status
);
    cmd_t  cmd;
    stat_t st;

    crt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
    );

    crt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .residue(residue), .modulus(modulus),
        .last(last), .cmd(cmd), .st(st), .solution(solution),
        .combined_modulus(combined_modulus), .status(status)
    );

    // The status is never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n) status != 2'd3)
        else $error("bad status");
    // Input and output are never offered together.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("overlap");
    // A waiting result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution) &&
        $stable(combined_modulus) && $stable(status))
        else $error("result changed while waiting");
endmodule
`default_nettype wire
